// File: sv/me_pkg.sv
// ----------------------------------------------------------------------------
// me_pkg
// shared widths, cell payload type and operation tags for modular exponentiation
// ----------------------------------------------------------------------------
package me_pkg;

	localparam int unsigned MOD_W   = 31;
	localparam int unsigned BASE_W  = 63;
	localparam int unsigned EXPIN_W = 63;
	localparam int unsigned MUL_W   = 32;
	localparam int unsigned ADDR_W  = 2;
	localparam int unsigned DATA_W  = 32;

	localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;
	localparam logic [ADDR_W-1:0] REG_MODULUS  = 2'd0;

	typedef enum logic [1:0] {
		TAG_RED = 2'd0,
		TAG_SQR = 2'd1,
		TAG_MUL = 2'd2
	} tag_t;

	// one operation travelling down the cell row
	typedef struct packed {
		logic             valid;
		tag_t             tag;
		logic [MOD_W-1:0] r;
		logic [MOD_W-1:0] a;
		logic [MUL_W-1:0] b;
	} cell_t;

endpackage

// File: sv/me_in_if.sv
// ----------------------------------------------------------------------------
// me_in_if
// input channel: mode, base and exponent with valid/ready
// ----------------------------------------------------------------------------
interface me_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [62:0] base;
	logic [62:0] exponent;

	modport source (output valid, input ready, output mode, output base, output exponent);
	modport sink (input valid, output ready, input mode, input base, input exponent);
endinterface

// File: sv/me_out_if.sv
// ----------------------------------------------------------------------------
// me_out_if
// output channel: result with valid/ready
// ----------------------------------------------------------------------------
interface me_out_if;
	logic        valid;
	logic        ready;
	logic [30:0] result;

	modport source (output valid, input ready, output result);
	modport sink (input valid, output ready, input result);
endinterface

// File: sv/me_cell.sv
// ----------------------------------------------------------------------------
// me_cell
// one step of interleaved modular multiplication: r = (2r + bit*a) mod m
// ----------------------------------------------------------------------------
module me_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [me_pkg::MOD_W-1:0]      m,
	input  me_pkg::cell_t                 d,
	output me_pkg::cell_t                 q
);
	import me_pkg::*;

	logic [MOD_W+1:0] t;
	logic [MOD_W+1:0] m1;
	logic [MOD_W+1:0] m2;
	logic [MOD_W+1:0] t_red;
	cell_t            nxt;

	always_comb begin
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		// t stays below 3m
		t  = {1'b0, d.r, 1'b0} + (d.b[MUL_W-1] ? {2'b00, d.a} : '0);
		if (t >= m2) begin
			t_red = t - m2;
		end else if (t >= m1) begin
			t_red = t - m1;
		end else begin
			t_red = t;
		end
		nxt       = d;
		nxt.r     = t_red[MOD_W-1:0];
		nxt.b     = {d.b[MUL_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q <= nxt;
		end
	end
endmodule

// File: sv/me_chain.sv
// ----------------------------------------------------------------------------
// me_chain
// row of multiplier cells, one multiplier bit per cell, msb first
// ----------------------------------------------------------------------------
module me_chain (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [me_pkg::MOD_W-1:0] m,
	input  me_pkg::cell_t            inj,
	output me_pkg::cell_t            res
);
	import me_pkg::*;

	cell_t link [MUL_W+1];

	assign link[0] = inj;

	for (genvar i = 0; i < MUL_W; i++) begin : g_cell
		me_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.m      (m),
			.d      (link[i]),
			.q      (link[i+1])
		);
	end

	assign res = link[MUL_W];
endmodule

// File: sv/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square and multiply on a cell row
// ----------------------------------------------------------------------------
// sequence: the base is reduced in two passes down the row, then a square, and a
//   multiply when the bit is set, per exponent bit up to the highest set bit
//   (square and multiply share the 32-cell row); one transaction at a time, a new
//   request is accepted only in the idle state, once the current one is finished
// reset: modulus returns to 1000000007, no transaction in flight, output empty
module modular_exponentiation #(
	parameter int unsigned EXP_BITS = 63
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [me_pkg::ADDR_W-1:0] paddr,
	input  logic [me_pkg::DATA_W-1:0] pwdata,
	output logic [me_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	me_in_if.sink                     req,
	me_out_if.source                  rsp
);
	import me_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED1,
		S_RED2,
		S_ISSUE,
		S_ISSUE_MUL,
		S_WAIT,
		S_FIN
	} state_t;

	state_t              state_q;
	logic [MOD_W-1:0]    modulus_q;
	logic [BASE_W-1:0]   base_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [MOD_W-1:0]    acc_q;
	logic [MOD_W-1:0]    pw_q;
	logic [1:0]          pend_q;
	logic                issued_q;
	logic                rsp_valid_q;
	logic [MOD_W-1:0]    result_q;

	cell_t               inj;
	cell_t               res;
	logic [EXPIN_W-1:0]  inv_exp;
	logic [EXP_BITS-1:0] exp_eff;
	logic [EXP_BITS-1:0] exp_next;
	logic                accept;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr == REG_MODULUS) ? {1'b0, modulus_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (psel && penable && pwrite && paddr == REG_MODULUS) begin
			modulus_q <= pwdata[MOD_W-1:0];
		end
	end

	me_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.m      (modulus_q),
		.inj    (inj),
		.res    (res)
	);

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.result = result_q;

	assign inv_exp  = {{(EXPIN_W-MOD_W){1'b0}}, modulus_q - MOD_W'(2)};
	assign exp_eff  = req.mode ? inv_exp[EXP_BITS-1:0] : req.exponent[EXP_BITS-1:0];
	assign exp_next = exp_q >> 1;

	always_comb begin
		inj = '0;
		unique case (state_q)
			S_RED1: begin
				inj.valid = !issued_q;
				inj.tag   = TAG_RED;
				inj.a     = MOD_W'(1);
				inj.b     = {1'b0, base_q[BASE_W-1:MUL_W]};
			end
			S_RED2: begin
				inj.valid = !issued_q;
				inj.tag   = TAG_RED;
				inj.r     = pw_q;
				inj.a     = MOD_W'(1);
				inj.b     = base_q[MUL_W-1:0];
			end
			S_ISSUE: begin
				inj.valid = 1'b1;
				inj.tag   = TAG_SQR;
				inj.a     = pw_q;
				inj.b     = {1'b0, pw_q};
			end
			S_ISSUE_MUL: begin
				inj.valid = 1'b1;
				inj.tag   = TAG_MUL;
				inj.a     = acc_q;
				inj.b     = {1'b0, pw_q};
			end
			default: begin
				inj = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			pend_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						base_q   <= req.base;
						exp_q    <= exp_eff;
						issued_q <= 1'b0;
						if (modulus_q == '0 || (req.mode && modulus_q < MOD_W'(2))) begin
							acc_q   <= '0;
							state_q <= S_FIN;
						end else if (exp_eff == '0) begin
							acc_q   <= MOD_W'(1);
							state_q <= S_FIN;
						end else begin
							acc_q   <= MOD_W'(1);
							state_q <= S_RED1;
						end
					end
				end
				S_RED1, S_RED2: begin
					if (res.valid) begin
						pw_q     <= res.r;
						issued_q <= 1'b0;
						state_q  <= (state_q == S_RED1) ? S_RED2 : S_ISSUE;
					end else begin
						issued_q <= 1'b1;
					end
				end
				S_ISSUE: begin
					if (exp_q[0]) begin
						pend_q  <= 2'd2;
						state_q <= S_ISSUE_MUL;
					end else begin
						pend_q  <= 2'd1;
						state_q <= S_WAIT;
					end
				end
				S_ISSUE_MUL: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (res.valid) begin
						if (res.tag == TAG_MUL) begin
							acc_q <= res.r;
						end else begin
							pw_q <= res.r;
						end
						pend_q <= pend_q - 2'd1;
						if (pend_q == 2'd1) begin
							exp_q   <= exp_next;
							state_q <= (exp_next == '0) ? S_FIN : S_ISSUE;
						end
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						result_q    <= acc_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// File: dv/modular_exponentiation_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// self-checking bench for the square-and-multiply modular exponentiation block
// ----------------------------------------------------------------------------
// a directed table covers reset modulus, field extremes and both modes, then the
// small-modulus corner cases follow; random transactions follow under several idling
// phases and modulus settings, each result checked against a local predictor
module modular_exponentiation_tb;
	import me_pkg::*;

	localparam int unsigned N_RANDOM  = 400;
	localparam int unsigned WATCHDOG  = 40000;
	localparam logic        MODE_POW  = 1'b0;
	localparam logic        MODE_INV  = 1'b1;

	typedef struct {
		logic        mode;
		logic [62:0] base;
		logic [62:0] exponent;
		logic        known;
		logic [30:0] result;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	me_in_if  req ();
	me_out_if rsp ();

	modular_exponentiation u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req.sink), .rsp(rsp.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [30:0] cur_modulus;
	logic [30:0] result_q[$];
	int unsigned errors = 0, n_sent = 0, n_checked = 0, idle_cycles = 0;
	int unsigned send_idle = 0, recv_stall = 0, hold_off = 0, n_moduli = 0;

	initial begin
		req.valid = 1'b0;
		req.mode = 1'b0;
		req.base = '0;
		req.exponent = '0;
		rsp.ready = 1'b0;
	end

	function automatic logic [30:0] power_mod(logic [62:0] b, logic [62:0] e,
			logic [30:0] m);
		logic [63:0] acc, pw;
		acc = 64'd1;
		if (m == 0) return '0;
		pw = {1'b0, b} % m;
		for (int i = 0; i < 63; i++) begin
			if (e[i]) acc = (acc * pw) % m;
			pw = (pw * pw) % m;
		end
		return acc[30:0];
	endfunction

	function automatic logic [30:0] predict_result(logic mode, logic [62:0] b,
			logic [62:0] e, logic [30:0] m);
		if (m == 0) return '0;
		if (mode == MODE_INV) begin
			if (m < 2) return '0;
			return power_mod(b, 63'(m - 31'd2), m);
		end
		return power_mod(b, e, m);
	endfunction

	task automatic report_mismatch(string what, logic [30:0] got, logic [30:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// receiver side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (req.valid && req.ready) idle_cycles <= 0;
		else if (rsp.valid && rsp.ready) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (rsp.valid && rsp.ready) begin
			if (result_q.size() == 0) begin
				$display("unexpected transaction, result %0d", rsp.result);
				errors++;
			end else begin
				logic [30:0] want;
				want = result_q.pop_front();
				if (rsp.result !== want) report_mismatch("result", rsp.result, want);
				n_checked++;
			end
		end
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired");
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic write_modulus(logic [30:0] m);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_MODULUS; pwdata <= {1'b0, m};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		cur_modulus = m;
		n_moduli++;
	endtask

	// valid stays up after acceptance until the next call replaces the item or takes it down, or drain takes it down
	task automatic send_item(logic mode, logic [62:0] b, logic [62:0] e);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1; req.mode <= mode; req.base <= b; req.exponent <= e;
		do @(posedge clk); while (!req.ready);
		result_q.push_back(predict_result(mode, b, e, cur_modulus));
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [62:0] rand63();
		return 63'({$urandom(), $urandom()});
	endfunction

	function automatic logic [62:0] rand_exp();
		case ($urandom_range(3))
			0: return 63'($urandom_range(15));
			1: return 63'($urandom());
			default: return rand63();
		endcase
	endfunction

	vec_t dir_tab[$];

	initial begin
		logic [30:0] moduli[6];
		logic [62:0] all_ones;
		all_ones = '1;
		moduli = '{31'h7fffffff, 31'd1, 31'd2, 31'd97, 31'd2147483629, 31'd1000};
		dir_tab = '{
			'{MODE_POW, 63'd5, 63'd0, 1'b1, 31'd1},
			'{MODE_POW, 63'd0, 63'd0, 1'b1, 31'd1},
			'{MODE_POW, 63'd0, 63'd5, 1'b1, 31'd0},
			'{MODE_POW, 63'd1000000007, 63'd3, 1'b1, 31'd0},
			'{MODE_POW, 63'd2, 63'd10, 1'b1, 31'd1024},
			'{MODE_POW, all_ones, all_ones, 1'b0, '0},
			'{MODE_POW, all_ones, 63'd1, 1'b0, '0},
			'{MODE_POW, 63'd3, all_ones, 1'b0, '0},
			'{MODE_INV, 63'd2, all_ones, 1'b1, 31'd500000004},
			'{MODE_INV, 63'd0, 63'd0, 1'b1, 31'd0},
			'{MODE_INV, all_ones, 63'd0, 1'b0, '0},
			'{MODE_INV, 63'd1000000006, 63'd7, 1'b1, 31'd1000000006}
		};
		cur_modulus = MODULUS_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			send_item(dir_tab[i].mode, dir_tab[i].base, dir_tab[i].exponent);
			if (dir_tab[i].known && result_q[$] !== dir_tab[i].result)
				report_mismatch("table", result_q[$], dir_tab[i].result);
		end
		drain();

		// small-modulus corners: modulus 1 and 2 in both modes
		write_modulus(31'd1);
		send_item(MODE_POW, 63'd9, 63'd0);
		send_item(MODE_POW, 63'd9, 63'd4);
		send_item(MODE_INV, 63'd9, 63'd0);
		drain();
		write_modulus(31'd2);
		send_item(MODE_INV, 63'd3, 63'd0);
		send_item(MODE_POW, 63'd3, 63'd1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_modulus(moduli[ph]);
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 73; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 73; end
				default: begin send_idle = 25; recv_stall = 25; end
			endcase
			if (ph == 4) hold_off = 3000;
			for (int k = 0; k < N_RANDOM / 6; k++) begin
				logic [62:0] b;
				b = ($urandom_range(3) == 0) ? 63'($urandom_range(3)) : rand63();
				if ($urandom_range(9) == 0) b = 63'(moduli[ph]) * 63'($urandom_range(5));
				send_item(1'($urandom_range(4) == 0), b, rand_exp());
			end
			drain();
		end
		write_modulus(MODULUS_RESET);

		$display("covered %0d transactions, %0d results checked, %0d modulus settings",
			n_sent, n_checked, n_moduli);
		$display("idling phases: none, sender, receiver, both; one long receiver hold-off");
		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
